>>> hdl/fcw_pkg.sv
package fcw_pkg;

   // Table store geometry and walk limit
   localparam int TABLE_BYTES = 8192;
   localparam int MAX_CHAIN   = 64;
   localparam int STORE_AW    = $clog2(TABLE_BYTES);

   // Field widths
   localparam int CLUSTER_W = 12;
   localparam int LBA_W     = 32;
   localparam int SPC_W     = 8;
   localparam int STEP_W    = 7;
   localparam int PROD_W    = CLUSTER_W + SPC_W;

   // First entry value that marks the end of a chain
   localparam logic [CLUSTER_W-1:0] END_MARK = 12'hFF8;
   // Lowest cluster number that maps to the data area
   localparam logic [CLUSTER_W-1:0] FIRST_CLUSTER = 12'd2;

   // Request actions
   localparam logic ACT_LOAD = 1'b0;
   localparam logic ACT_WALK = 1'b1;

   // Register indexes
   localparam logic REG_FIRST_DATA_LBA = 1'b0;
   localparam logic REG_CLUSTER_SIZE   = 1'b1;

   // Controller to datapath commands
   typedef struct packed {
      logic write;     // store one table byte from the request
      logic start;     // take start cluster, clear step count
      logic rd_lo;     // read low byte of the entry pair
      logic rd_hi;     // read high byte of the entry pair
      logic cap_lo;    // capture low byte
      logic cap_next;  // capture high byte and decode next entry
      logic mul;       // register (cluster - 2) * sectors_per_cluster
      logic load_out;  // load the result register
      logic advance;   // move to the next cluster
   } cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic bad;   // current cluster below 2
      logic last;  // current result ends the walk
   } sts_type;

endpackage

>>> hdl/fcw_ram.sv
module fcw_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8192
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hdl/fcw_datapath.sv
module fcw_datapath (
   input  logic                                clock,
   input  logic                                reset,
   input  fcw_pkg::cmd_type                    cmd,
   output fcw_pkg::sts_type                    sts,
   input  logic [12:0]                         req_table_address,
   input  logic [7:0]                          req_table_byte,
   input  logic [fcw_pkg::CLUSTER_W-1:0]       req_start_cluster,
   input  logic                                csr_wr,
   input  logic                                csr_index,
   input  logic [31:0]                         csr_data,
   output logic [fcw_pkg::CLUSTER_W-1:0]       rsp_cluster,
   output logic [fcw_pkg::LBA_W-1:0]           rsp_cluster_lba,
   output logic                                rsp_last,
   output logic                                rsp_truncated,
   output logic                                rsp_bad_cluster
);

   logic [fcw_pkg::LBA_W-1:0]     first_lba_ff;
   logic [fcw_pkg::SPC_W-1:0]     spc_ff;
   logic [fcw_pkg::CLUSTER_W-1:0] cur_ff;
   logic [fcw_pkg::STEP_W-1:0]    step_ff;
   logic [fcw_pkg::CLUSTER_W-1:0] next_ff;
   logic [7:0]                    lo_ff;
   logic [fcw_pkg::PROD_W-1:0]    prod_ff;

   logic [fcw_pkg::CLUSTER_W-1:0] out_cluster_ff;
   logic [fcw_pkg::LBA_W-1:0]     out_lba_ff;
   logic                          out_last_ff;
   logic                          out_trunc_ff;
   logic                          out_bad_ff;

   logic                          wr_en;
   logic [fcw_pkg::STORE_AW-1:0]  rd_addr;
   logic [12:0]                   pair_off;
   logic [12:0]                   byte_addr;
   logic [7:0]                    rd_data;
   logic [15:0]                   pair;
   logic [fcw_pkg::CLUSTER_W-1:0] entry;
   logic                          at_end;
   logic                          at_limit;
   logic                          is_bad;

   // Table store
   assign wr_en = cmd.write && (32'(req_table_address) < fcw_pkg::TABLE_BYTES);

   // Entry pair offset is cluster * 3 / 2
   assign pair_off  = {1'b0, cur_ff} + {2'b0, cur_ff[fcw_pkg::CLUSTER_W-1:1]};
   assign byte_addr = cmd.rd_hi ? pair_off + 13'd1 : pair_off;
   assign rd_addr   = byte_addr[fcw_pkg::STORE_AW-1:0];

   fcw_ram #(
      .WIDTH(8),
      .DEPTH(fcw_pkg::TABLE_BYTES)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (req_table_address[fcw_pkg::STORE_AW-1:0]),
      .wr_data (req_table_byte),
      .rd_en   (cmd.rd_lo | cmd.rd_hi),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Unpack the 12-bit entry by cluster parity
   assign pair  = {rd_data, lo_ff};
   assign entry = cur_ff[0] ? pair[15:4] : pair[11:0];

   // Walk status
   assign is_bad   = (cur_ff < fcw_pkg::FIRST_CLUSTER);
   assign at_end   = (next_ff >= fcw_pkg::END_MARK);
   assign at_limit = (step_ff == fcw_pkg::STEP_W'(fcw_pkg::MAX_CHAIN - 1));
   assign sts.bad  = is_bad;
   assign sts.last = is_bad | at_end | at_limit;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         first_lba_ff <= '0;
         spc_ff       <= fcw_pkg::SPC_W'(1);
      end else if (csr_wr) begin
         unique case (csr_index)
            fcw_pkg::REG_FIRST_DATA_LBA: first_lba_ff <= csr_data;
            fcw_pkg::REG_CLUSTER_SIZE:   spc_ff       <= csr_data[fcw_pkg::SPC_W-1:0];
         endcase
      end
   end

   // Walk position
   always_ff @(posedge clock) begin
      if (reset) begin
         cur_ff  <= '0;
         step_ff <= '0;
      end else if (cmd.start) begin
         cur_ff  <= req_start_cluster;
         step_ff <= '0;
      end else if (cmd.advance) begin
         cur_ff  <= next_ff;
         step_ff <= step_ff + fcw_pkg::STEP_W'(1);
      end
   end

   // Entry decode and sector offset product
   always_ff @(posedge clock) begin
      if (cmd.cap_lo) begin
         lo_ff <= rd_data;
      end
      if (cmd.cap_next) begin
         next_ff <= entry;
      end
      if (cmd.mul) begin
         prod_ff <= fcw_pkg::PROD_W'(cur_ff - fcw_pkg::FIRST_CLUSTER)
                    * fcw_pkg::PROD_W'(spc_ff);
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         out_cluster_ff <= cur_ff;
         out_lba_ff     <= is_bad ? '0 : first_lba_ff + fcw_pkg::LBA_W'(prod_ff);
         out_last_ff    <= is_bad | at_end | at_limit;
         out_trunc_ff   <= !is_bad && !at_end && at_limit;
         out_bad_ff     <= is_bad;
      end
   end

   assign rsp_cluster     = out_cluster_ff;
   assign rsp_cluster_lba = out_lba_ff;
   assign rsp_last        = out_last_ff;
   assign rsp_truncated   = out_trunc_ff;
   assign rsp_bad_cluster = out_bad_ff;

   // A result is never produced past the chain limit
   a_step_bound: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> (32'(step_ff) < fcw_pkg::MAX_CHAIN))
      else $error("step count beyond chain limit");

endmodule

>>> hdl/fcw_ctrl.sv
module fcw_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic             req_action,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output fcw_pkg::cmd_type cmd,
   input  fcw_pkg::sts_type sts
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_CHECK,
      S_READ_LO,
      S_READ_HI,
      S_EMIT
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free = !rsp_valid_ff || rsp_ready;

   // Next state and commands
   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      cmd          = '0;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               if (req_action == fcw_pkg::ACT_WALK) begin
                  cmd.start = 1'b1;
                  state_in  = S_CHECK;
               end else begin
                  cmd.write = 1'b1;
               end
            end
         end
         S_CHECK: begin
            if (sts.bad) begin
               state_in = S_EMIT;
            end else begin
               cmd.rd_lo = 1'b1;
               cmd.mul   = 1'b1;
               state_in  = S_READ_LO;
            end
         end
         S_READ_LO: begin
            cmd.cap_lo = 1'b1;
            cmd.rd_hi  = 1'b1;
            state_in   = S_READ_HI;
         end
         S_READ_HI: begin
            cmd.cap_next = 1'b1;
            state_in     = S_EMIT;
         end
         S_EMIT: begin
            if (out_free) begin
               cmd.load_out = 1'b1;
               rsp_valid_in = 1'b1;
               if (sts.last) begin
                  state_in = S_IDLE;
               end else begin
                  cmd.advance = 1'b1;
                  state_in    = S_CHECK;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // State and response valid
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // Result register is only loaded when its previous result is gone
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> (!rsp_valid_ff || rsp_ready))
      else $error("result overwritten before it was taken");

   // A walk request always starts the cluster check
   a_walk_start: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_action == fcw_pkg::ACT_WALK) |=> (state_ff == S_CHECK))
      else $error("walk request did not start a walk");

   // High byte read always follows the low byte read
   a_read_order: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_READ_HI) |-> ($past(state_ff) == S_READ_LO))
      else $error("entry bytes read out of order");

endmodule

>>> hdl/fat12_cluster_chain_walker.sv
// FAT12 cluster chain walker.
// Requests (req_*): a load request (req_action 0) writes req_table_byte at
// req_table_address of the internal 8 KiB table store; no
// response. A walk request (req_action 1) follows the chain from
// req_start_cluster and returns one response (rsp_*) per visited cluster:
// cluster number, first sector LBA, and last/truncated/bad_cluster flags.
// Registers (csr_*): index 0 first_data_lba, index 1 cluster size in sectors;
// writes are taken every cycle and must only be made while the block is idle.
// Each cluster goes through a check, two byte reads one after the other
// from the single-read-port table RAM, and the result load; a cluster
// below 2 skips the reads. req_ready is high only between walks, one
// request at a time.
// When rsp_ready is low the finished response waits in the output register
// and the walk halts at its next result until that response is taken.
// Reset (synchronous) clears the walk state and registers to
// first_data_lba 0, cluster size 1; the table store keeps its contents
// and must be loaded before any entry of it is read.
module fat12_cluster_chain_walker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_action,
   input  logic [12:0] req_table_address,
   input  logic [7:0]  req_table_byte,
   input  logic [11:0] req_start_cluster,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [11:0] rsp_cluster,
   output logic [31:0] rsp_cluster_lba,
   output logic        rsp_last,
   output logic        rsp_truncated,
   output logic        rsp_bad_cluster,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [31:0] csr_data
);

   fcw_pkg::cmd_type cmd;
   fcw_pkg::sts_type sts;

   // Register writes are always taken
   assign csr_ready = 1'b1;

   fcw_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_action (req_action),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .cmd        (cmd),
      .sts        (sts)
   );

   fcw_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .sts               (sts),
      .req_table_address (req_table_address),
      .req_table_byte    (req_table_byte),
      .req_start_cluster (req_start_cluster),
      .csr_wr            (csr_valid & csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data),
      .rsp_cluster       (rsp_cluster),
      .rsp_cluster_lba   (rsp_cluster_lba),
      .rsp_last          (rsp_last),
      .rsp_truncated     (rsp_truncated),
      .rsp_bad_cluster   (rsp_bad_cluster)
   );

endmodule
